/* rtl/core/jcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcs_pkg
// Types and character constants shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package jcs_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [2:0] {
      MODE_NORMAL     = 3'd0,
      MODE_SLASH      = 3'd1,
      MODE_LINE       = 3'd2,
      MODE_BLOCK      = 3'd3,
      MODE_BLOCK_STAR = 3'd4,
      MODE_STRING     = 3'd5,
      MODE_STRING_ESC = 3'd6
   } mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
      logic       run_last;
   } rsp_type;

   // Results of one item: count is 0..2, first goes out before second.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } scan_type;

   function automatic rsp_type mk_rsp(logic [7:0] b, logic vld, logic eot, logic last);
      rsp_type r;
      r.out_byte    = b;
      r.byte_valid  = vld;
      r.end_of_text = eot;
      r.run_last    = last;
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/jcs_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcs_scan
// Scan mode register and per-byte decode into up to two results.
// ----------------------------------------------------------------------------
module jcs_scan
   import jcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire req_type  item,
   output scan_type      scan
);

   mode_type mode_ff;
   mode_type mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (step) begin
         mode_ff <= mode_in;
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (item.op == OP_END) begin
         mode_in = MODE_NORMAL;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (item.in_byte == CH_SLASH) mode_in = MODE_LINE;
               else if (item.in_byte == CH_STAR) mode_in = MODE_BLOCK;
               else if (item.in_byte == CH_QUOTE) mode_in = MODE_STRING;
               else mode_in = MODE_NORMAL;
            end
            MODE_LINE: begin
               if (item.in_byte == CH_NL) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (item.in_byte == CH_STAR) mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (item.in_byte == CH_SLASH) mode_in = MODE_NORMAL;
               else if (item.in_byte != CH_STAR) mode_in = MODE_BLOCK;
            end
            MODE_STRING: begin
               if (item.in_byte == CH_QUOTE) mode_in = MODE_NORMAL;
               else if (item.in_byte == CH_BSLASH) mode_in = MODE_STRING_ESC;
            end
            MODE_STRING_ESC: mode_in = MODE_STRING;
            default: begin
               if (item.in_byte == CH_SLASH) mode_in = MODE_SLASH;
               else if (item.in_byte == CH_QUOTE) mode_in = MODE_STRING;
               else mode_in = MODE_NORMAL;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      scan.count  = 2'd0;
      scan.first  = mk_rsp(8'h00, 1'b0, 1'b0, 1'b0);
      scan.second = mk_rsp(8'h00, 1'b0, 1'b0, 1'b0);
      if (item.op == OP_END) begin
         scan.count = 2'd1;
         if (mode_ff == MODE_SLASH) scan.first = mk_rsp(CH_SLASH, 1'b1, 1'b1, 1'b1);
         else scan.first = mk_rsp(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
         unique case (mode_ff) inside
            MODE_SLASH: begin
               if (item.in_byte != CH_SLASH && item.in_byte != CH_STAR) begin
                  // held slash released ahead of the byte
                  scan.count  = 2'd2;
                  scan.first  = mk_rsp(CH_SLASH, 1'b1, 1'b0, 1'b0);
                  scan.second = mk_rsp(item.in_byte, 1'b1, 1'b0, 1'b1);
               end
            end
            MODE_LINE: begin
               if (item.in_byte == CH_NL) begin
                  scan.count = 2'd1;
                  scan.first = mk_rsp(item.in_byte, 1'b1, 1'b0, 1'b1);
               end
            end
            MODE_BLOCK, MODE_BLOCK_STAR: ;
            MODE_STRING, MODE_STRING_ESC: begin
               scan.count = 2'd1;
               scan.first = mk_rsp(item.in_byte, 1'b1, 1'b0, 1'b1);
            end
            default: begin
               if (item.in_byte != CH_SLASH) begin
                  scan.count = 2'd1;
                  scan.first = mk_rsp(item.in_byte, 1'b1, 1'b0, 1'b1);
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/core/jcs_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcs_out_buf
// Two-slot result register; serializes the results of one item.
// ----------------------------------------------------------------------------
module jcs_out_buf
   import jcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire scan_type scan,
   output logic          free,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic [1:0] rem_ff, rem_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       take;

   assign take      = rsp_valid && rsp_ready;
   assign rsp_valid = (rem_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   // room for a new pair once the last pending result leaves
   assign free      = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);

   always_comb begin
      rem_in   = rem_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         rem_in   = scan.count;
         slot0_in = scan.first;
         slot1_in = scan.second;
      end else if (take) begin
         rem_in   = rem_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule
`default_nettype wire

/* rtl/core/jsonc_comment_stripper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsonc_comment_stripper_top
// Streaming JSONC comment stripper, one text byte per transfer.
// ----------------------------------------------------------------------------
// Text bytes come in on req_ (op = 0) and the cleaned text leaves on rsp_.
// Line comments are dropped up to their newline (the newline is kept),
// block comments up to and including the closing star-slash; quoted
// strings, with backslash escapes, pass untouched. A slash is held until
// the following byte shows whether it opens a comment. An end transfer
// (op = 1) flushes a held slash, or yields a bare marker with byte_valid 0,
// sets end_of_text and returns to normal mode. run_last marks the final
// result caused by each input transfer; a transfer may cause none.
//
// Rate: one input transfer per cycle while rsp_ready is high. Each item
// passes through the input register, then the result register. A
// held slash followed by an ordinary byte causes two results; the result
// register drains one per cycle, so that case holds the input register until
// the second of the two is taken. The single mode register is the only loop.
// ----------------------------------------------------------------------------
module jsonc_comment_stripper_top
   import jcs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic     in_vld_ff, in_vld_in;
   req_type  in_ff;
   scan_type scan;
   logic     free;
   logic     load;

   // item in the input register moves on once the result register has room
   assign load      = in_vld_ff && free;
   assign req_ready = !in_vld_ff || load;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   jcs_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (load),
      .item  (in_ff),
      .scan  (scan)
   );

   jcs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (load),
      .scan      (scan),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for jsonc_comment_stripper_top.
// ----------------------------------------------------------------------------
// The bench feeds text bytes and end-of-text transfers into the stripper.
// A scan-mode model inside the bench predicts every cleaned byte, end
// marker and run_last flag. Each result transfer is checked in order
// against that prediction.
// A short directed text covers these cases:
//   - extreme byte values
//   - held slashes
//   - an empty block comment
//   - an escape at the end of the text
//   - an unterminated block comment
//   - end markers in string-escape, slash, block and normal modes
// Randomized JSONC-like fragments and raw noise follow.
// Three idle profiles run in turn: receiver idles more often, then sender
// idles more often, then neither side idles.
// ----------------------------------------------------------------------------
module testbench;
   import jcs_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int ITEMS_PER_PHASE = 600;
   localparam int DRAIN_CYCLES = 10;    // input and result registers, with margin
   localparam int MAX_REPORTS = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type  pending_q[$];   // text transfers not yet presented
   rsp_type  cleaned_q[$];   // predicted output, oldest first
   rsp_type  step_out[$];    // scratch: results of one input transfer
   mode_type scan_state = MODE_NORMAL;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic req_fire = 1'b0;    // req transfer happened at the last rising edge
   int  stall_cycles = 0;
   int  mismatches = 0;

   jsonc_comment_stripper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Scan-mode model
   // ------------------------------------------------------------------
   function automatic rsp_type out_item(input logic [7:0] b, input logic vld,
                                        input logic eot);
      rsp_type r;
      r = {b, vld, eot, 1'b0};
      return r;
   endfunction

   // Byte seen as plain text: a slash is held, a quote opens a string.
   function automatic void take_plain(input logic [7:0] b);
      if (b == CH_SLASH) begin
         scan_state = MODE_SLASH;
      end else begin
         scan_state = (b == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
         step_out.push_back(out_item(b, 1'b1, 1'b0));
      end
   endfunction

   function automatic void strip_step(input req_type item);
      rsp_type r;
      step_out.delete();
      if (item.op == OP_END) begin
         // A held slash is flushed as the closing byte; otherwise, emit a bare marker.
         if (scan_state == MODE_SLASH)
            step_out.push_back(out_item(CH_SLASH, 1'b1, 1'b1));
         else
            step_out.push_back(out_item(8'h00, 1'b0, 1'b1));
         scan_state = MODE_NORMAL;
      end else begin
         case (scan_state)
            MODE_SLASH: begin
               if (item.in_byte == CH_SLASH) begin
                  scan_state = MODE_LINE;
               end else if (item.in_byte == CH_STAR) begin
                  scan_state = MODE_BLOCK;
               end else begin
                  // False alarm: release the slash, then treat the byte as text.
                  step_out.push_back(out_item(CH_SLASH, 1'b1, 1'b0));
                  take_plain(item.in_byte);
               end
            end
            MODE_LINE: begin
               if (item.in_byte == CH_NL) begin
                  step_out.push_back(out_item(item.in_byte, 1'b1, 1'b0));
                  scan_state = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (item.in_byte == CH_STAR)
                  scan_state = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (item.in_byte == CH_SLASH)
                  scan_state = MODE_NORMAL;
               else if (item.in_byte != CH_STAR)
                  scan_state = MODE_BLOCK;
            end
            MODE_STRING: begin
               step_out.push_back(out_item(item.in_byte, 1'b1, 1'b0));
               if (item.in_byte == CH_QUOTE)
                  scan_state = MODE_NORMAL;
               else if (item.in_byte == CH_BSLASH)
                  scan_state = MODE_STRING_ESC;
            end
            MODE_STRING_ESC: begin
               step_out.push_back(out_item(item.in_byte, 1'b1, 1'b0));
               scan_state = MODE_STRING;
            end
            default: take_plain(item.in_byte);
         endcase
      end
      if (step_out.size() > 0) begin
         r = step_out.pop_back();
         r.run_last = 1'b1;
         step_out.push_back(r);
      end
      foreach (step_out[i])
         cleaned_q.push_back(step_out[i]);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void add_item(input logic op, input logic [7:0] b);
      req_type t;
      t.op      = op;
      t.in_byte = b;
      pending_q.push_back(t);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      add_item(OP_BYTE, b);
   endfunction

   // The byte field of an end transfer is a don't-care, so it is randomized.
   function automatic void add_end();
      add_item(OP_END, 8'($urandom_range(255)));
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   // Random byte, skewed toward the characters that steer the scanner.
   function automatic logic [7:0] text_byte();
      case ($urandom_range(9))
         0:       return CH_SLASH;
         1:       return CH_STAR;
         2:       return CH_QUOTE;
         3:       return CH_BSLASH;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents the next pending transfer on the falling edge, with
   // random gaps. A presented transfer holds until it is accepted.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: on each rising edge, predict from an input transfer first,
   // then check any result transfer. Predicting first keeps the order
   // correct even if a result could leave in the same cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            strip_step(req_data);

         if (rsp_valid && rsp_ready) begin
            if (cleaned_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected result byte %02h valid %0b eot %0b last %0b",
                           $realtime, rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.end_of_text, rsp_data.run_last);
            end else begin
               want = cleaned_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.end_of_text !== want.end_of_text ||
                   rsp_data.run_last !== want.run_last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                              $realtime,
                              want.out_byte, want.byte_valid, want.end_of_text,
                              want.run_last, rsp_data.out_byte, rsp_data.byte_valid,
                              rsp_data.end_of_text, rsp_data.run_last);
               end
            end
         end

         // Watchdog: time out after too long with no transfer on either channel.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            add_byte(8'h00);
            add_byte(8'hFF);
            add_text("/**/");          // a star right after the opener closes the comment
            add_text("/\"a\\");        // slash+quote gives two results; escape left open
            add_end();
            add_text("//c\n");         // newline survives the line comment
            add_text("/");             // held slash flushed by end
            add_end();
            add_text("/*z");           // unterminated block: all dropped
            add_end();
            add_end();                 // bare marker in normal mode
         end

         target = pending_q.size() + ITEMS_PER_PHASE;
         while (pending_q.size() < target) begin
            case ($urandom_range(9))
               0, 1: begin
                  repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
               end
               2: begin
                  add_byte(CH_QUOTE);
                  repeat ($urandom_range(0, 6)) begin
                     if ($urandom_range(4) == 0) begin
                        add_byte(CH_BSLASH);
                        add_byte(text_byte());
                     end else begin
                        add_byte(8'($urandom_range(255)));
                     end
                  end
                  if ($urandom_range(6) != 0)
                     add_byte(CH_QUOTE);
               end
               3: begin
                  add_text("//");
                  repeat ($urandom_range(0, 6)) add_byte(text_byte());
                  if ($urandom_range(4) != 0)
                     add_byte(CH_NL);
                  else
                     add_end();
               end
               4: begin
                  add_text("/*");
                  repeat ($urandom_range(0, 6)) add_byte(text_byte());
                  case ($urandom_range(4))
                     0:       add_end();
                     1:       add_text("**/");
                     default: add_text("*/");
                  endcase
               end
               5: begin
                  add_byte(CH_SLASH);
                  add_byte(text_byte());
               end
               6: add_end();
               7, 8: begin
                  repeat ($urandom_range(1, 8)) add_byte(text_byte());
               end
               default: begin
                  // Raw noise, end transfers included.
                  repeat ($urandom_range(1, 8))
                     add_item(($urandom_range(9) == 0) ? OP_END : OP_BYTE,
                              8'($urandom_range(255)));
               end
            endcase
         end

         while (pending_q.size() != 0)
            @(posedge clock);
      end

      while (req_valid || cleaned_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (cleaned_q.size() != 0)
         $display("%0d predicted results never arrived", cleaned_q.size());
      if (mismatches == 0 && cleaned_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/jcs_pkg.sv
rtl/core/jcs_scan.sv
rtl/core/jcs_out_buf.sv
rtl/core/jsonc_comment_stripper_top.sv
sim/testbench.sv
